// ===== design/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_pkg
// Types and constants shared by the pulse period meter and its divider.
// ----------------------------------------------------------------------------
package ppm_pkg;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int CH_W    = 4;
  localparam int TIME_W  = 16;
  localparam int CNT_W   = 32;
  localparam int FREQ_W  = 14;

  // Default channel count
  localparam int DEF_CHANNELS = 16;

  // Fixed values
  localparam logic [TIME_W-1:0] TIME_INVALID = 16'hFFFF;
  localparam logic [FREQ_W-1:0] FREQ_SCALE   = 14'd10000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CONFIG = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  // Status codes
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_NOCFG = 1'b1;

  // Input beat
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] timebase_ms;
  } in_t;

  // Result beat
  typedef struct packed {
    logic              status;
    logic [CNT_W-1:0]  event_count;
    logic [TIME_W-1:0] period_ms;
    logic [FREQ_W-1:0] frequency;
    logic [TIME_W-1:0] age_ms;
  } out_t;

  // Per-channel measurement entry
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] last_period;
  } chan_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_DIV
  } state_t;

endpackage

// ===== design/multichannel_pulse_period_meter.sv =====
// ----------------------------------------------------------------------------
// multichannel_pulse_period_meter
// Multichannel edge counter with period, frequency and age per channel.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Tick advances
// the 16-bit ms time base, edge counts one edge on a configured channel,
// configure sets the channel timebase (first time also clears the channel),
// query reports count, period, frequency (0.1 Hz) and age, clear zeroes the
// count. Query and clear give exactly one result beat, on out_data for one
// cycle with out_valid high; the receiver cannot stall, so a result is never
// held. Other commands give no result.
// Tick, configure, unknown command and any command on an unconfigured
// channel are done in idle; edge, clear and a query without a frequency
// read the channel memory, then write back; a query with a frequency then
// runs the 14-step iterative divider before its result is given.
// Per-channel state is in two one-read, one-write memories (counters and
// timebases); channel enable bits are flip-flops.
// Reset (synchronous, rst_n low) clears the time base and all enable bits;
// busy is high while reset is held. No clearing pass is needed.
// ----------------------------------------------------------------------------
module multichannel_pulse_period_meter #(
  parameter int CHANNELS = ppm_pkg::DEF_CHANNELS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ppm_pkg::in_t  in_data,
  output logic          out_valid,
  output ppm_pkg::out_t out_data
);
  import ppm_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHX_W = (IDX_W > CH_W) ? IDX_W : CH_W;

  // Channel memories
  chan_t             cnt_mem [CHANNELS];
  logic [TIME_W-1:0] tb_mem  [CHANNELS];

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CHANNELS-1:0] en_r, en_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;
  out_t              res_r, res_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  chan_t             rd_r;
  logic [TIME_W-1:0] rd_tb_r;

  // Memory port controls
  logic              rd_en;
  logic              a_we;
  chan_t             a_wdata;
  logic              tb_we;

  logic              accept;
  logic [CHX_W-1:0]  ch_ext;
  logic [IDX_W-1:0]  idx_in;
  logic              ch_in_range;
  logic              ch_ok;

  // Query evaluation
  logic              per_valid;
  logic [TIME_W-1:0] age_raw;
  logic              stale;
  logic [TIME_W-1:0] age_q;
  logic [TIME_W-1:0] lp_q;
  logic              measure;
  logic [TIME_W-1:0] per_q;
  logic              need_div;
  logic [TIME_W:0]   sum17;
  logic [TIME_W:0]   dbl17;
  logic [TIME_W-1:0] divisor;
  logic [TIME_W-1:0] edge_d;

  logic              div_start;
  logic              div_done;
  logic [FREQ_W-1:0] div_q;

  // Handshake and channel decode
  assign busy        = (state_r != ST_IDLE) || !rst_n;
  assign accept      = start && !busy;
  assign ch_ext      = CHX_W'(in_data.channel);
  assign idx_in      = ch_ext[IDX_W-1:0];
  assign ch_in_range = (int'(in_data.channel) < CHANNELS);
  assign ch_ok       = ch_in_range && en_r[idx_in];

  // Query arithmetic on the read entry
  always_comb begin
    per_valid = (rd_r.last_period != TIME_INVALID);
    age_raw   = now_r - rd_r.last_time;
    stale     = per_valid && (rd_tb_r < age_raw);
    age_q     = (per_valid && !stale) ? age_raw : TIME_INVALID;
    lp_q      = stale ? TIME_INVALID : rd_r.last_period;
    measure   = (rd_tb_r != '0) && (age_q < rd_tb_r);
    per_q     = measure ? ((lp_q == '0) ? TIME_W'(1) : lp_q) : TIME_INVALID;
    need_div  = measure && (lp_q != '0);
    sum17     = {1'b0, lp_q} + {1'b0, age_q};
    dbl17     = {lp_q, 1'b0};
    divisor   = (dbl17 < {1'b0, age_q}) ? sum17[TIME_W:1] : lp_q;
    edge_d    = now_r - rd_r.last_time;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && ch_ok &&
            (in_data.cmd inside {CMD_EDGE, CMD_QUERY, CMD_CLEAR})) begin
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        if (cmd_r == CMD_QUERY && need_div) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    now_nxt       = now_r;
    en_nxt        = en_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    res_nxt       = res_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    rd_en         = 1'b0;
    a_we          = 1'b0;
    a_wdata       = rd_r;
    tb_we         = 1'b0;
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_data.cmd;
          idx_nxt = idx_in;
          case (in_data.cmd)
            CMD_TICK: now_nxt = now_r + 1'b1;
            CMD_EDGE: rd_en = ch_ok;
            CMD_CONFIG: begin
              if (ch_in_range) begin
                tb_we = 1'b1;
                if (!en_r[idx_in]) begin
                  en_nxt[idx_in] = 1'b1;
                  a_we           = 1'b1;
                  a_wdata        = '0;
                end
              end
            end
            CMD_QUERY, CMD_CLEAR: begin
              if (ch_ok) begin
                rd_en = 1'b1;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: STAT_NOCFG, event_count: '0,
                                  period_ms: TIME_INVALID, frequency: '0,
                                  age_ms: TIME_INVALID};
              end
            end
            default: ;
          endcase
        end
      end
      ST_RMW: begin
        case (cmd_r)
          CMD_EDGE: begin
            a_we                = 1'b1;
            a_wdata.count       = rd_r.count + 1'b1;
            a_wdata.last_period = (edge_d == '0) ? TIME_W'(1) : edge_d;
            a_wdata.last_time   = now_r;
          end
          CMD_CLEAR: begin
            a_we          = 1'b1;
            a_wdata.count = '0;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: STAT_OK, event_count: '0,
                              period_ms: TIME_INVALID, frequency: '0,
                              age_ms: TIME_INVALID};
          end
          CMD_QUERY: begin
            // stale period is invalidated in the entry
            a_we                = stale;
            a_wdata.last_period = lp_q;
            res_nxt = '{status: STAT_OK, event_count: rd_r.count,
                        period_ms: per_q, frequency: '0, age_ms: age_q};
            if (need_div) begin
              div_start = 1'b1;
            end else begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = res_nxt;
            end
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt           = res_r;
          out_data_nxt.frequency = div_q;
        end
      end
      default: ;
    endcase
  end

  // Channel memories: write in idle or write-back, registered read
  always_ff @(posedge clk) begin
    if (a_we) begin
      cnt_mem[(state_r == ST_IDLE) ? idx_in : idx_r] <= a_wdata;
    end
    if (tb_we) begin
      tb_mem[idx_in] <= in_data.timebase_ms;
    end
    if (rd_en) begin
      rd_r    <= cnt_mem[idx_in];
      rd_tb_r <= tb_mem[idx_in];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      en_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    res_r      <= res_nxt;
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
  end

  ppm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE)) else $error("result while sequencer busy");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV)) else $error("divider done outside divide state");
  a_nocfg_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == STAT_NOCFG) |->
      (out_data_r.event_count == '0 && out_data_r.period_ms == TIME_INVALID &&
       out_data_r.frequency == '0)) else $error("unconfigured result not fixed");
  a_rmw_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RMW) |=> (state_r != ST_RMW)) else $error("write-back repeated");

endmodule

// ===== design/ppm_div.sv =====
// ----------------------------------------------------------------------------
// ppm_div
// Restoring divider, one quotient bit per cycle: FREQ_SCALE / divisor.
// ----------------------------------------------------------------------------
module ppm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ppm_pkg::TIME_W-1:0]  divisor,
  output logic                        done,
  output logic [ppm_pkg::FREQ_W-1:0]  quotient
);
  import ppm_pkg::*;

  localparam int STEP_W = $clog2(FREQ_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FREQ_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] d_r, d_nxt;
  logic [FREQ_W-1:0] q_r, q_nxt;

  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;
  logic              ge;

  // One trial subtraction per cycle
  always_comb begin
    shifted = {rem_r, q_r[FREQ_W-1]};
    diff    = shifted - {1'b0, d_r};
    ge      = (shifted >= {1'b0, d_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      d_nxt    = divisor;
      q_nxt    = FREQ_SCALE;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      q_nxt   = {q_r[FREQ_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done longer than one cycle");
  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still iterating");

endmodule

// ===== dv/meter_monitor.sv =====
// ----------------------------------------------------------------------------
// meter_monitor
// Watches the command and result channels of the pulse period meter, keeps
// its own copy of the per-channel measurement state, predicts every result
// beat and compares it field by field with what the block reports.
// ----------------------------------------------------------------------------
module meter_monitor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  ppm_pkg::in_t  in_data,
  input  logic          out_valid,
  input  ppm_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import ppm_pkg::*;

  localparam int NCH = DEF_CHANNELS;

  // Shadow state of the meter
  logic [TIME_W-1:0] now_ms;
  logic [CNT_W-1:0]  edges_seen [NCH];
  logic [TIME_W-1:0] edge_stamp [NCH];
  logic [TIME_W-1:0] period_held [NCH];
  logic [TIME_W-1:0] window_ms [NCH];
  bit                ch_on [NCH];

  // Reports predicted but not yet seen on the result port
  out_t reports_due [$];
  int   n_errors = 0;

  // Blank answer used by clear and unconfigured channels
  function automatic out_t blank_report(input logic st);
    out_t r;
    r.status      = st;
    r.event_count = '0;
    r.period_ms   = TIME_INVALID;
    r.frequency   = '0;
    r.age_ms      = TIME_INVALID;
    return r;
  endfunction

  // Apply one command beat to the shadow state; returns 1 if a report follows
  function automatic bit meter_apply(input in_t b, output out_t r);
    int unsigned       ch;
    int unsigned       tb;
    int unsigned       age;
    int unsigned       p;
    int unsigned       scale;
    logic [TIME_W-1:0] dt;
    bit                has;
    ch    = 32'(b.channel);
    has   = 1'b0;
    scale = 32'(FREQ_SCALE);
    r     = blank_report(STAT_NOCFG);
    case (b.cmd)
      CMD_TICK: begin
        now_ms = now_ms + 1'b1;
      end
      CMD_EDGE: begin
        if (ch_on[ch]) begin
          dt              = now_ms - edge_stamp[ch];
          edges_seen[ch]  = edges_seen[ch] + 1'b1;
          period_held[ch] = (dt == '0) ? TIME_W'(1) : dt;
          edge_stamp[ch]  = now_ms;
        end
      end
      CMD_CONFIG: begin
        // first configure enables and wipes the channel
        if (!ch_on[ch]) begin
          ch_on[ch]       = 1'b1;
          edges_seen[ch]  = '0;
          edge_stamp[ch]  = '0;
          period_held[ch] = '0;
        end
        window_ms[ch] = b.timebase_ms;
      end
      CMD_QUERY: begin
        has = 1'b1;
        if (ch_on[ch]) begin
          r.status = STAT_OK;
          tb       = 32'(window_ms[ch]);
          age      = 32'(TIME_INVALID);
          // an edge older than the timebase invalidates the period
          if (period_held[ch] != TIME_INVALID) begin
            dt  = now_ms - edge_stamp[ch];
            age = 32'(dt);
            if (tb < age) begin
              period_held[ch] = TIME_INVALID;
              age             = 32'(TIME_INVALID);
            end
          end
          if (tb != 0 && age < tb) begin
            p           = 32'(period_held[ch]);
            r.period_ms = (p == 0) ? TIME_W'(1) : TIME_W'(p);
            if (p != 0) begin
              // stretch the period once the signal has gone quiet
              if (p * 2 < age)
                p = (p + age) / 2;
              r.frequency = FREQ_W'(scale / p);
            end
          end
          r.event_count = edges_seen[ch];
          r.age_ms      = TIME_W'(age);
        end
      end
      CMD_CLEAR: begin
        has = 1'b1;
        if (ch_on[ch]) begin
          edges_seen[ch] = '0;
          r              = blank_report(STAT_OK);
        end
      end
      default: ;
    endcase
    return has;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Predict on accepted beats, compare on result strobes
  always @(posedge clk) begin : watch
    out_t nxt;
    out_t want;
    if (!rst_n) begin
      now_ms = '0;
      for (int i = 0; i < NCH; i++) begin
        edges_seen[i]  = '0;
        edge_stamp[i]  = '0;
        period_held[i] = '0;
        window_ms[i]   = '0;
        ch_on[i]       = 1'b0;
      end
      reports_due.delete();
    end else begin
      if (start && !busy) begin
        if (meter_apply(in_data, nxt))
          reports_due.push_back(nxt);
      end
      if (out_valid) begin
        if (reports_due.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
        end else begin
          want = reports_due.pop_front();
          check_field("status", CNT_W'(want.status), CNT_W'(out_data.status));
          check_field("event_count", want.event_count, out_data.event_count);
          check_field("period_ms", CNT_W'(want.period_ms), CNT_W'(out_data.period_ms));
          check_field("frequency", CNT_W'(want.frequency), CNT_W'(out_data.frequency));
          check_field("age_ms", CNT_W'(want.age_ms), CNT_W'(out_data.age_ms));
        end
      end
    end
    pending    <= reports_due.size();
    fail_count <= n_errors;
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the multichannel pulse period meter. A directed
// opening covers unconfigured channels, unknown commands, zero and full
// timebases and period invalidation; random traffic with tick bursts
// follows. A monitor does the checking.
// ----------------------------------------------------------------------------
module tb_top;
  import ppm_pkg::*;

  localparam int RANDOM_BEATS = 600;
  localparam int CALM_BEATS   = 100;
  localparam int STALL_LIMIT  = 5000;
  localparam int SETTLE       = 40;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   stall_cycles = 0;
  int   beats_sent;

  multichannel_pulse_period_meter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  meter_monitor u_monitor (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles with no beat moving on either channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_t beat(input logic [CMD_W-1:0] cmd, input int unsigned ch,
                               input int unsigned tb);
    in_t b;
    b.cmd         = cmd;
    b.channel     = CH_W'(ch);
    b.timebase_ms = TIME_W'(tb);
    return b;
  endfunction

  // Random command beat; traffic is focused on a few channels
  function automatic in_t rand_beat();
    in_t         b;
    int unsigned r;
    int unsigned mode;
    b.channel     = ($urandom_range(0, 4) == 0) ? CH_W'($urandom_range(0, 15))
                                                 : CH_W'($urandom_range(0, 3));
    b.timebase_ms = TIME_W'($urandom);
    r             = $urandom_range(0, 99);
    if (r < 30)
      b.cmd = CMD_TICK;
    else if (r < 55)
      b.cmd = CMD_EDGE;
    else if (r < 63) begin
      b.cmd = CMD_CONFIG;
      mode  = $urandom_range(0, 9);
      if (mode == 0)
        b.timebase_ms = '0;
      else if (mode == 1)
        b.timebase_ms = TIME_INVALID;
      else if (mode > 2)
        b.timebase_ms = TIME_W'($urandom_range(1, 60));
    end else if (r < 85)
      b.cmd = CMD_QUERY;
    else if (r < 95)
      b.cmd = CMD_CLEAR;
    else
      b.cmd = CMD_W'($urandom_range(5, 7));
    return b;
  endfunction

  // Present one beat, optionally after a short gap, and hold it until taken
  task automatic send_beat(input in_t b, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= in_t'($urandom);
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  // Hold off the sender until every expected report is back
  task automatic drain_reports();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic tick_run(input int unsigned n);
    repeat (n) send_beat(beat(CMD_TICK, 0, 0), 1'b0);
  endtask

  initial begin
    start      = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    beats_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening
    send_beat(beat(CMD_QUERY, 0, 0), 1'b1);          // unconfigured query
    send_beat(beat(CMD_CLEAR, 15, 16'hFFFF), 1'b1);  // unconfigured clear
    send_beat(beat(CMD_EDGE, 7, 0), 1'b1);           // edge ignored
    send_beat(beat(3'd5, 1, 16'hFFFF), 1'b1);        // unknown commands
    send_beat(beat(3'd6, 2, 0), 1'b1);
    send_beat(beat(3'd7, 15, 0), 1'b1);
    send_beat(beat(CMD_CONFIG, 0, 0), 1'b1);         // timebase zero
    send_beat(beat(CMD_QUERY, 0, 0), 1'b1);
    send_beat(beat(CMD_CONFIG, 15, 16'hFFFF), 1'b1); // widest timebase
    send_beat(beat(CMD_EDGE, 15, 0), 1'b1);          // equal times give 1
    send_beat(beat(CMD_QUERY, 15, 0), 1'b1);
    tick_run(3);
    send_beat(beat(CMD_EDGE, 15, 0), 1'b1);
    send_beat(beat(CMD_TICK, 0, 0), 1'b1);
    send_beat(beat(CMD_QUERY, 15, 0), 1'b1);
    send_beat(beat(CMD_CONFIG, 15, 2), 1'b1);        // repeat keeps state
    tick_run(2);
    send_beat(beat(CMD_QUERY, 15, 0), 1'b1);         // too old
    send_beat(beat(CMD_QUERY, 15, 0), 1'b1);
    send_beat(beat(CMD_CLEAR, 15, 0), 1'b1);
    send_beat(beat(CMD_QUERY, 15, 0), 1'b1);
    drain_reports();

    // Random traffic
    while (beats_sent < RANDOM_BEATS + 25) begin
      if ($urandom_range(0, 60) == 0)
        drain_reports();
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(2, 40))
          send_beat(beat(CMD_TICK, 0, $urandom), beats_sent < RANDOM_BEATS - CALM_BEATS);
      else
        send_beat(rand_beat(), beats_sent < RANDOM_BEATS - CALM_BEATS);
    end

    // Wind down
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
